/* rtl/gf2scb_pkg.sv */
// ----------------------------------------------------------------------------
// gf2scb_pkg
// Shared sizes for the GF(2) canonical basis block.
// ----------------------------------------------------------------------------
package gf2scb_pkg;

  // Store depth, vector width and number of reported basis rows
  localparam int MAX_VECTORS = 16;   // 4..64
  localparam int VECTOR_BITS = 16;   // 4..16
  localparam int BASIS_ROWS  = 4;    // 1..4

  // Fixed port widths
  localparam int VEC_W  = 16;
  localparam int KEY_W  = 64;
  localparam int RANK_W = 5;
  localparam int OUT_ROWS = 4;

  // Derived sizes
  localparam int CNT_W = $clog2(MAX_VECTORS + 1);
  localparam int IDX_W = $clog2(MAX_VECTORS);
  localparam int BIT_W = $clog2(VECTOR_BITS);

  typedef logic [VECTOR_BITS-1:0] vec_t;

endpackage

/* rtl/gf2_subspace_canonical_basis.sv */
// ----------------------------------------------------------------------------
// gf2_subspace_canonical_basis
// Collects GF(2) vectors and reports the reduced row echelon basis of their span.
// ----------------------------------------------------------------------------
//
//   channel | ports                                      | handshake
//   --------+--------------------------------------------+----------------------
//   in      | in_vector[15:0], in_last                    | in_valid / in_stall
//   out     | out_row0..3, out_packed_key, out_rank,      | out_valid / out_stall
//           | out_full_rank                               |
//
// Sequence: the item carrying last starts the reduction, which walks the
// pivot bits from the top bit down, one bit per cycle through the shared
// eliminator. The result appears the cycle after the bit 0 step.
// Reset: rst_n (synchronous, active low) clears the fill count and the
// sequencer; the vector store is not cleared, entries past the fill count
// are never used.
// Stalls: in_stall is high during reduction. While a result waits for the
// output side, plain vectors of the next set still load, but an item with
// last is held until the result is taken.
//
// Elimination: each step picks the first loaded row with the pivot bit set
// as pivot, XORs it into every loaded row with that bit (the pivot row
// itself becomes zero) and into every basis row with that bit, then appends
// the pivot to the basis while a basis row is free. Later pivots come from
// store rows that lost all earlier pivot bits, so the basis ends up reduced.

module gf2_subspace_canonical_basis (
  input  logic                        clk,
  input  logic                        rst_n,
  // input item
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gf2scb_pkg::VEC_W-1:0]  in_vector,
  input  logic                        in_last,
  // result item
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gf2scb_pkg::VEC_W-1:0]  out_row0,
  output logic [gf2scb_pkg::VEC_W-1:0]  out_row1,
  output logic [gf2scb_pkg::VEC_W-1:0]  out_row2,
  output logic [gf2scb_pkg::VEC_W-1:0]  out_row3,
  output logic [gf2scb_pkg::KEY_W-1:0]  out_packed_key,
  output logic [gf2scb_pkg::RANK_W-1:0] out_rank,
  output logic                        out_full_rank
);

  import gf2scb_pkg::*;

  typedef enum logic [0:0] {
    S_LOAD,
    S_REDUCE
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [BIT_W-1:0]    bit_r;
  logic [RANK_W-1:0]   rank_r;
  logic                out_valid_r;

  vec_t                store_r   [MAX_VECTORS];
  vec_t                store_nxt [MAX_VECTORS];
  vec_t                basis_r   [BASIS_ROWS];
  vec_t                basis_nxt [BASIS_ROWS];

  logic [MAX_VECTORS-1:0] hit;
  logic [MAX_VECTORS-1:0] sel;
  logic                found;
  vec_t                pivot;
  logic [RANK_W-1:0]   rank_nxt;
  logic                in_acc;
  logic                out_acc;
  logic                has_room;
  logic [VEC_W-1:0]    rows_out [OUT_ROWS];

  assign in_stall = (state_r != S_LOAD) || (out_valid_r && in_last);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign has_room = count_r < CNT_W'(MAX_VECTORS);

  // Shared eliminator: pivot search over loaded rows, then XOR everywhere
  always_comb begin
    found = 1'b0;
    pivot = '0;
    for (int i = 0; i < MAX_VECTORS; i++) begin
      hit[i] = (CNT_W'(i) < count_r) && store_r[i][bit_r];
      sel[i] = hit[i] && !found;
      found  = found || hit[i];
      if (sel[i]) begin
        pivot = pivot | store_r[i];
      end
    end
    for (int i = 0; i < MAX_VECTORS; i++) begin
      store_nxt[i] = hit[i] ? (store_r[i] ^ pivot) : store_r[i];
    end
    for (int j = 0; j < BASIS_ROWS; j++) begin
      basis_nxt[j] = basis_r[j][bit_r] ? (basis_r[j] ^ pivot) : basis_r[j];
      if (found && (rank_r == RANK_W'(j))) begin
        basis_nxt[j] = pivot;
      end
    end
    rank_nxt = rank_r + RANK_W'(found);
  end

  // Sequencer and registered result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      bit_r       <= BIT_W'(VECTOR_BITS - 1);
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_acc) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (has_room) begin
              count_r <= count_r + CNT_W'(1);
            end
            if (in_last) begin
              state_r <= S_REDUCE;
              bit_r   <= BIT_W'(VECTOR_BITS - 1);
              rank_r  <= '0;
            end
          end
        end
        S_REDUCE: begin
          rank_r <= rank_nxt;
          if (bit_r == '0) begin
            state_r     <= S_LOAD;
            count_r     <= '0;
            out_valid_r <= 1'b1;
          end else begin
            bit_r <= bit_r - BIT_W'(1);
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // Vector store and basis rows
  always_ff @(posedge clk) begin
    if (state_r == S_REDUCE) begin
      store_r <= store_nxt;
      basis_r <= basis_nxt;
    end else if (in_acc) begin
      if (has_room) begin
        store_r[count_r[IDX_W-1:0]] <= in_vector[VECTOR_BITS-1:0];
      end
      if (in_last) begin
        for (int j = 0; j < BASIS_ROWS; j++) begin
          basis_r[j] <= '0;
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < OUT_ROWS; j++) begin
      rows_out[j] = '0;
    end
    for (int j = 0; j < BASIS_ROWS; j++) begin
      rows_out[j] = VEC_W'(basis_r[j]);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row0       = rows_out[0];
  assign out_row1       = rows_out[1];
  assign out_row2       = rows_out[2];
  assign out_row3       = rows_out[3];
  assign out_packed_key = {rows_out[3], rows_out[2], rows_out[1], rows_out[0]};
  assign out_rank       = rank_r;
  assign out_full_rank  = (rank_r == RANK_W'(BASIS_ROWS));

  // --------------------------------------------------------------------------
  a_last_starts_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> state_r == S_REDUCE && rank_r == '0)
    else $error("last item did not start reduction");

  a_result_after_reduce: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_REDUCE) && $past(bit_r == '0))
    else $error("result raised outside the final pivot step");

  a_rank_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REDUCE |-> rank_r <= RANK_W'(count_r))
    else $error("rank exceeds loaded vector count");

  a_empty_rank_zero_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && rank_r == '0 |-> out_row0 == '0)
    else $error("nonzero row reported with rank zero");

endmodule

/* sim/tb_gf2_subspace_canonical_basis.sv */
// ----------------------------------------------------------------------------
// tb_gf2_subspace_canonical_basis
// Self-checking bench: random and directed vector sets go in, and each
// reported reduced row echelon basis is checked against a Gauss-Jordan
// predictor that runs inside the bench.
// ----------------------------------------------------------------------------

// Tracks the open vector set and holds the basis predicted for each closed set
class rref_checker;
  typedef struct packed {
    logic [gf2scb_pkg::OUT_ROWS-1:0][gf2scb_pkg::VEC_W-1:0] row;  // row0 at lsb
    logic [gf2scb_pkg::RANK_W-1:0]                          rank;
    logic                                                   full;
  } basis_t;

  gf2scb_pkg::vec_t set_rows[$];
  basis_t           expected_bases[$];
  int               errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return expected_bases.size();
  endfunction

  // Gauss-Jordan over the open set, pivots from the top bit down
  function basis_t reduce_set();
    gf2scb_pkg::vec_t m[gf2scb_pkg::MAX_VECTORS];
    gf2scb_pkg::vec_t tmp;
    basis_t res;
    int n;
    int r;
    int sel;
    n = set_rows.size();
    r = 0;
    res = '0;
    for (int i = 0; i < n; i++) m[i] = set_rows[i];
    for (int b = gf2scb_pkg::VECTOR_BITS - 1; b >= 0; b--) begin
      sel = -1;
      for (int i = r; i < n; i++) begin
        if (sel < 0 && m[i][b]) sel = i;
      end
      if (sel >= 0) begin
        tmp = m[r];
        m[r] = m[sel];
        m[sel] = tmp;
        for (int i = 0; i < n; i++) begin
          if (i != r && m[i][b]) m[i] = m[i] ^ m[r];
        end
        r++;
      end
    end
    for (int i = 0; i < gf2scb_pkg::OUT_ROWS; i++) begin
      if (i < gf2scb_pkg::BASIS_ROWS && i < r) res.row[i] = 16'(m[i]);
    end
    res.rank = 5'(r);
    res.full = (r == gf2scb_pkg::BASIS_ROWS);
    return res;
  endfunction

  // Accepted input item: store it (full store drops it), close the set on last
  function void note_vector(logic [gf2scb_pkg::VEC_W-1:0] v, logic last);
    if (set_rows.size() < gf2scb_pkg::MAX_VECTORS)
      set_rows.insert(set_rows.size(), v[gf2scb_pkg::VECTOR_BITS-1:0]);
    if (last) begin
      expected_bases.insert(expected_bases.size(), reduce_set());
      set_rows.delete();
    end
  endfunction

  function void compare_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch on %s: expected %h actual %h", $time, fname, exp_v, act_v);
    end
  endfunction

  // Accepted result item against the oldest predicted basis
  function void check_basis(logic [gf2scb_pkg::VEC_W-1:0] r0, logic [gf2scb_pkg::VEC_W-1:0] r1,
                            logic [gf2scb_pkg::VEC_W-1:0] r2, logic [gf2scb_pkg::VEC_W-1:0] r3,
                            logic [gf2scb_pkg::KEY_W-1:0] key,
                            logic [gf2scb_pkg::RANK_W-1:0] rank, logic full);
    basis_t e;
    if (expected_bases.size() == 0) begin
      errors++;
      $display("%0t unexpected result: expected none actual key %h rank %0d", $time, key, rank);
      return;
    end
    e = expected_bases.pop_front();
    compare_field("row0", 64'(e.row[0]), 64'(r0));
    compare_field("row1", 64'(e.row[1]), 64'(r1));
    compare_field("row2", 64'(e.row[2]), 64'(r2));
    compare_field("row3", 64'(e.row[3]), 64'(r3));
    compare_field("packed_key", 64'(e.row), key);
    compare_field("rank", 64'(e.rank), 64'(rank));
    compare_field("full_rank", 64'(e.full), 64'(full));
  endfunction
endclass

module tb_gf2_subspace_canonical_basis;
  import gf2scb_pkg::*;

  localparam int ITEM_TARGET  = 550;     // random part stops once this many items went in
  localparam int QUIET_AFTER  = 470;     // no idling on either side past this point
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 300000;

  // Shapes of random vector sets
  typedef enum int {SET_RANDOM, SET_SPAN4, SET_SPAN2, SET_SPARSE} set_style_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [VEC_W-1:0]  in_vector = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [VEC_W-1:0]  out_row0;
  logic [VEC_W-1:0]  out_row1;
  logic [VEC_W-1:0]  out_row2;
  logic [VEC_W-1:0]  out_row3;
  logic [KEY_W-1:0]  out_packed_key;
  logic [RANK_W-1:0] out_rank;
  logic              out_full_rank;

  rref_checker checker_h = new();
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;        // end of run: both sides go flat out
  bit  idle_this_set = 1'b1;
  int  stall_left = 0;
  int  calm_left = 0;

  gf2_subspace_canonical_basis dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_vector(in_vector), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_row0(out_row0), .out_row1(out_row1), .out_row2(out_row2), .out_row3(out_row3),
    .out_packed_key(out_packed_key), .out_rank(out_rank), .out_full_rank(out_full_rank)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both handshakes are observed at the rising edge; the bench drives only on
  // the falling edge, so nothing here races with the block's own updates.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && in_valid && !in_stall)
      checker_h.note_vector(in_vector, in_last);
    if (rst_n && out_valid && !out_stall)
      checker_h.check_basis(out_row0, out_row1, out_row2, out_row3,
                            out_packed_key, out_rank, out_full_rank);
    if (cycle_count > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Output back-pressure: random bursts of stalled cycles, broken up by calm
  // stretches so that results also drain back to back now and then.
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall <= 1'b0;
      calm_left <= $urandom_range(20, 60);
    end else if ($urandom_range(0, 9) < 3) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);   // burst length minus the current cycle
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One input item; returns at the falling edge after it was taken. in_valid
  // stays high into the next item unless an idle burst comes first.
  task automatic send_item(input logic [VEC_W-1:0] v, input logic last);
    int gap;
    if (!quiet && idle_this_set && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_vector <= v;
    in_last   <= last;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // A whole set; content shaped so that rank four is common, with low rank,
  // high rank and sparse sets mixed in.
  task automatic send_set(input int len, input set_style_t style);
    logic [VEC_W-1:0] gens[4];
    logic [VEC_W-1:0] v;
    logic [3:0]       pick;
    for (int g = 0; g < 4; g++) gens[g] = 16'($urandom);
    idle_this_set = ($urandom_range(0, 9) < 7);
    for (int i = 0; i < len; i++) begin
      pick = 4'($urandom);
      v = '0;
      case (style)
        SET_SPAN4: begin
          for (int g = 0; g < 4; g++) if (pick[g]) v = v ^ gens[g];
        end
        SET_SPAN2: begin
          for (int g = 0; g < 2; g++) if (pick[g]) v = v ^ gens[g];
        end
        SET_SPARSE: begin
          v = 16'(1) << $urandom_range(0, 15);
          if (pick[0]) v = v | (16'(1) << $urandom_range(0, 15));
        end
        default: v = 16'($urandom);
      endcase
      send_item(v, i == len - 1);
    end
  endtask

  initial begin
    int len;
    int roll;
    set_style_t style;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero set of one vector, all-ones alone
    send_item(16'h0000, 1'b1);
    send_item(16'hFFFF, 1'b1);
    // exactly four independent rows, the lowest pivot at bit 0
    send_item(16'h8000, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h00F0, 1'b0);
    send_item(16'h1234, 1'b1);
    // duplicate rows, rank below four
    send_item(16'hAAAA, 1'b0);
    send_item(16'hAAAA, 1'b0);
    send_item(16'h5555, 1'b1);
    // pivot row found further down, needs a swap
    send_item(16'h0F00, 1'b0);
    send_item(16'hF000, 1'b0);
    send_item(16'hFF00, 1'b1);
    // rank above four: only the first four rows are reported
    for (int i = 0; i < 6; i++) send_item(16'h8000 >> i, i == 5);

    // Store overflow: vectors past the store depth are dropped, last still closes
    send_set(MAX_VECTORS + 4, SET_RANDOM);

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
      roll = $urandom_range(0, 19);
      if (roll < 9) style = SET_SPAN4;
      else if (roll < 12) style = SET_SPAN2;
      else if (roll < 15) style = SET_SPARSE;
      else style = SET_RANDOM;
      if ($urandom_range(0, 11) == 0) len = $urandom_range(MAX_VECTORS - 2, MAX_VECTORS + 4);
      else if (style == SET_SPAN4) len = $urandom_range(4, 8);
      else len = $urandom_range(1, 8);
      send_set(len, style);
    end
    in_valid <= 1'b0;

    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (checker_h.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gf2scb_pkg.sv
rtl/gf2_subspace_canonical_basis.sv
sim/tb_gf2_subspace_canonical_basis.sv
